// File: src/color_bin_first_seen_renumber_assert.svh
// assertion helpers for the bin renumbering block
`ifndef COLOR_BIN_FIRST_SEEN_RENUMBER_ASSERT_SVH
`define COLOR_BIN_FIRST_SEEN_RENUMBER_ASSERT_SVH

// same-cycle implication
`define CBFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cbfs_pkg.sv
`timescale 1ns / 1ps

package cbfs_pkg;

	localparam int MAX_BINS = 64;
	localparam int QW       = $clog2(MAX_BINS);
	localparam int N_W      = 7;
	localparam int NN_W     = 2 * QW + 1;
	localparam int ADDR_W   = 3 * QW;
	localparam int IDX_W    = 18;
	localparam int CNT_W    = 19;
	localparam int EPOCH_W  = 8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RAW,
		ST_READ,
		ST_LOOK
	} state_t;

	typedef struct packed {
		logic               tag_we;
		logic               idx_we;
		logic [ADDR_W-1:0]  addr;
		logic [EPOCH_W-1:0] tag;
		logic [IDX_W-1:0]   idx;
	} store_wr_t;

endpackage

// File: src/cbfs_store.sv
`timescale 1ns / 1ps

module cbfs_store (
	input  logic                        clk,
	input  cbfs_pkg::store_wr_t         wr,
	input  logic                        rd_en,
	input  logic [cbfs_pkg::ADDR_W-1:0] rd_addr,
	output logic [cbfs_pkg::EPOCH_W-1:0] rd_tag,
	output logic [cbfs_pkg::IDX_W-1:0]  rd_idx
);
	import cbfs_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	// epoch of last visit per bin, zero means never seen
	logic [EPOCH_W-1:0] tag_mem [DEPTH];
	// compact index per bin, valid only where the tag matches
	logic [IDX_W-1:0]   idx_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.tag_we) begin
			tag_mem[wr.addr] <= wr.tag;
		end
		if (rd_en) begin
			rd_tag <= tag_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.idx_we) begin
			idx_mem[wr.addr] <= wr.idx;
		end
		if (rd_en) begin
			rd_idx <= idx_mem[rd_addr];
		end
	end

endmodule

// File: src/color_bin_first_seen_renumber.sv
// result strobe (done): registered from ST_LOOK, after the start transfer passes ST_RAW and ST_READ
// a new pixel is taken only in ST_IDLE, after the read-modify-write of the bin store for the last one
// reset: bins_per_channel 64, counter 0; a pass then writes zero to all 262144 epoch tags (busy high)
// start_image bumps an 8-bit epoch; every 255th one repeats that clear pass
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
`include "color_bin_first_seen_renumber_assert.svh"

module color_bin_first_seen_renumber (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       start_image,
	input  logic [7:0]                 blue,
	input  logic [7:0]                 green,
	input  logic [7:0]                 red,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cbfs_pkg::N_W-1:0]   cfg_data,
	output logic                       done,
	output logic [cbfs_pkg::IDX_W-1:0] compact_index,
	output logic                       is_new_bin,
	output logic [cbfs_pkg::CNT_W-1:0] used_bins
);
	import cbfs_pkg::*;

	function automatic logic [QW-1:0] quant(input logic [7:0] c, input logic [N_W-1:0] n);
		logic [14:0] p;
		p = 15'(c) * 15'(n);
		return p[13:8];
	endfunction

	state_t state_q, state_d;

	logic [N_W-1:0]     bins_q;
	logic [N_W-1:0]     n_eff;
	logic [13:0]        nn_full;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               pend_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]   next_q;
	logic               done_q;

	logic               start_s1;
	logic [QW-1:0]      qb_s1, qg_s1, qr_s1;
	logic [N_W-1:0]     n_s1;
	logic [NN_W-1:0]    nn_s1;
	logic [ADDR_W-1:0]  raw_s2;
	logic [ADDR_W-1:0]  raw_d;
	logic [ADDR_W-1:0]  term_g, term_r;

	logic [IDX_W-1:0]   index_q;
	logic               new_q;
	logic [CNT_W-1:0]   used_q;

	store_wr_t          wr;
	logic               rd_en;
	logic [EPOCH_W-1:0] rd_tag;
	logic [IDX_W-1:0]   rd_idx;
	logic               hit;
	logic               accept;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		if (bins_q == '0) begin
			n_eff = N_W'(1);
		end else if (bins_q > N_W'(MAX_BINS)) begin
			n_eff = N_W'(MAX_BINS);
		end else begin
			n_eff = bins_q;
		end
	end

	assign nn_full = 14'(n_eff) * 14'(n_eff);

	assign term_g = ADDR_W'(n_s1) * ADDR_W'(qg_s1);
	assign term_r = ADDR_W'(nn_s1) * ADDR_W'(qr_s1);
	assign raw_d  = ADDR_W'(qb_s1) + term_g + term_r;

	assign hit = (rd_tag == epoch_q);

	cbfs_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (raw_s2),
		.rd_tag  (rd_tag),
		.rd_idx  (rd_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_d = pend_q ? ST_READ : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RAW;
				end
			end
			ST_RAW: begin
				state_d = (start_s1 && epoch_q == '1) ? ST_CLEAR : ST_READ;
			end
			ST_READ:  state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		wr    = '0;
		rd_en = 1'b0;
		busy  = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				wr.tag_we = 1'b1;
				wr.addr   = clr_addr_q;
			end
			ST_IDLE: busy = 1'b0;
			ST_RAW: ;
			ST_READ: rd_en = 1'b1;
			ST_LOOK: begin
				if (!hit) begin
					wr.tag_we = 1'b1;
					wr.idx_we = 1'b1;
					wr.addr   = raw_s2;
					wr.tag    = epoch_q;
					wr.idx    = next_q[IDX_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			pend_q     <= 1'b0;
			epoch_q    <= EPOCH_W'(1);
			next_q     <= '0;
			bins_q     <= N_W'(MAX_BINS);
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_LOOK);
			if (cfg_valid && cfg_ready) begin
				bins_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == '1) begin
					pend_q <= 1'b0;
				end
			end
			if (state_q == ST_RAW && start_s1) begin
				next_q <= '0;
				if (epoch_q == '1) begin
					epoch_q <= EPOCH_W'(1);
					pend_q  <= 1'b1;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
			if (state_q == ST_LOOK && !hit) begin
				next_q <= next_q + CNT_W'(1);
			end
		end
	end

	// pixel pipeline and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= start_image;
			qb_s1    <= quant(blue, n_eff);
			qg_s1    <= quant(green, n_eff);
			qr_s1    <= quant(red, n_eff);
			n_s1     <= n_eff;
			nn_s1    <= nn_full[NN_W-1:0];
		end
		if (state_q == ST_RAW) begin
			raw_s2 <= raw_d;
		end
		if (state_q == ST_LOOK) begin
			if (hit) begin
				index_q <= rd_idx;
				new_q   <= 1'b0;
				used_q  <= next_q;
			end else begin
				index_q <= next_q[IDX_W-1:0];
				new_q   <= 1'b1;
				used_q  <= next_q + CNT_W'(1);
			end
		end
	end

	assign done          = done_q;
	assign compact_index = index_q;
	assign is_new_bin    = new_q;
	assign used_bins     = used_q;

	`CBFS_ASSERT_NXT(a_done_after_look, state_q == ST_LOOK, done, "result strobe missing after lookup")
	`CBFS_ASSERT_IMP(a_index_below_count, done, CNT_W'(compact_index) < used_bins, "index not below count")
	`CBFS_ASSERT_IMP(a_new_is_last, done && is_new_bin, used_bins == CNT_W'(compact_index) + CNT_W'(1), "new bin not last index")
	`CBFS_ASSERT_IMP(a_epoch_nonzero, state_q != ST_CLEAR, epoch_q != '0, "epoch zero outside clearing")

endmodule
